@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the noise reduction design files.
// Each macro expects clk and arst_n in the enclosing module's scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tpnr_pkg.sv @@
// ----------------------------------------------------------------------------
// tpnr_pkg
// Types, constants and the per-channel filter for temporal noise reduction.
// ----------------------------------------------------------------------------
package tpnr_pkg;

	// Frame store geometry
	localparam int MAX_PIXELS = 4194304;
	localparam int POS_W      = $clog2(MAX_PIXELS);
	localparam int CNT_W      = 23;
	localparam int CMP_W      = (POS_W + 1 > CNT_W) ? POS_W + 1 : CNT_W;

	// Channel and register widths
	localparam int CH_W       = 8;
	localparam int LEVEL_W    = 4;
	localparam int CFG_DATA_W = 23;
	localparam int CFG_IDX_W  = 1;

	// Register reset values
	localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(10);
	localparam logic [CNT_W-1:0]   FRAME_RST = CNT_W'(4194304);

	// Divide by three: x * 683 >> 11 is exact for x <= 765
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;

	// Queue depths
	localparam int IQ_DEPTH = 4;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL        = 1'b0,
		REG_FRAME_PIXELS = 1'b1
	} cfg_reg_t;

	// Classified input item, front to back
	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  alpha;
		logic             invalid;
		logic             last;
		logic [POS_W-1:0] pos;
	} pix_item_t;

	// Result item
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
		logic            last;
	} pix_res_t;

	// One color channel: keep, blend or hold depending on distance to history
	function automatic logic [CH_W-1:0] filter_chan(
		input logic [CH_W-1:0]    cur,
		input logic [CH_W-1:0]    prev,
		input logic [LEVEL_W-1:0] lvl
	);
		logic [CH_W-1:0]   diff;
		logic [CH_W+1:0]   sum;
		logic [CH_W+11:0]  prod;
		logic [CH_W-1:0]   res;
		diff = (cur >= prev) ? (cur - prev) : (prev - cur);
		sum  = {1'b0, cur, 1'b0} + {2'b00, prev};
		prod = (CH_W+12)'(sum) * (CH_W+12)'(DIV3_MUL);
		if (diff < {{(CH_W-LEVEL_W){1'b0}}, lvl}) begin
			if (diff > {{(CH_W-LEVEL_W+1){1'b0}}, lvl[LEVEL_W-1:1]}) begin
				res = prod[DIV3_SHIFT +: CH_W];
			end else begin
				res = prev;
			end
		end else begin
			res = cur;
		end
		return res;
	endfunction

endpackage

@@ design/tpnr_front.sv @@
// ----------------------------------------------------------------------------
// tpnr_front
// Accepts pixels, tags each with its frame position and end-of-frame flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpnr_front
	import tpnr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [CH_W-1:0]     red_in,
	input  logic [CH_W-1:0]     green_in,
	input  logic [CH_W-1:0]     blue_in,
	input  logic [CH_W-1:0]     alpha_in,
	input  logic                history_invalid,
	input  logic [CNT_W-1:0]    frame_pixels,
	input  logic                iq_full,
	output logic                iq_push,
	output pix_item_t           iq_item
);

	logic [POS_W-1:0] pos_q;
	logic [CMP_W-1:0] pos_inc;
	logic [CMP_W-1:0] frame_cnt;
	logic [CMP_W-1:0] frame_max;
	logic             last;

	// Clamp frame size to the store depth
	assign frame_max = CMP_W'(MAX_PIXELS);
	assign frame_cnt = (CMP_W'(frame_pixels) > frame_max) ? frame_max : CMP_W'(frame_pixels);
	assign pos_inc   = CMP_W'(pos_q) + CMP_W'(1);
	assign last      = (pos_inc >= frame_cnt);

	assign iq_push = push && !iq_full;

	// Item to the queue
	always_comb begin
		iq_item.red     = red_in;
		iq_item.green   = green_in;
		iq_item.blue    = blue_in;
		iq_item.alpha   = alpha_in;
		iq_item.invalid = history_invalid;
		iq_item.last    = last;
		iq_item.pos     = pos_q;
	end

	// Raster position, wraps at end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (iq_push) begin
			pos_q <= last ? '0 : pos_inc[POS_W-1:0];
		end
	end

	`CHK_NEXT(a_pos_wrap, iq_push && last, pos_q == '0, "position did not wrap at frame end")

endmodule

@@ design/tpnr_fifo.sv @@
// ----------------------------------------------------------------------------
// tpnr_fifo
// Short queue between the front and the back; flags full and empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpnr_fifo
	import tpnr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  pix_item_t wr_item,
	output logic      full,
	input  logic      rd,
	output pix_item_t rd_item,
	output logic      empty
);

	pix_item_t        slot_q [IQ_DEPTH];
	logic [IQ_AW-1:0] wp_q;
	logic [IQ_AW-1:0] rp_q;
	logic [IQ_CW-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == IQ_CW'(IQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = slot_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : wp_q + IQ_AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : rp_q + IQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + IQ_CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - IQ_CW'(1);
			end
		end
	end

	`CHK_IMPL(a_iq_bound, 1'b1, cnt_q <= IQ_CW'(IQ_DEPTH), "input queue count over depth")

endmodule

@@ design/tpnr_back.sv @@
// ----------------------------------------------------------------------------
// tpnr_back
// Reads history, filters each channel, writes history back, queues results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpnr_back
	import tpnr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LEVEL_W-1:0] level,
	input  logic               iq_empty,
	input  pix_item_t          iq_item,
	output logic               iq_pop,
	input  logic               pop,
	output logic               empty,
	output pix_res_t           res
);

	logic [3*CH_W-1:0] hist_mem [MAX_PIXELS];

	pix_item_t         item_s1;
	logic              valid_s1;
	logic [3*CH_W-1:0] rd_s1;
	logic              fwd_q;
	logic [3*CH_W-1:0] fwd_data_q;
	logic [3*CH_W-1:0] prev;
	logic [3*CH_W-1:0] wr_data;
	logic              adv;
	logic              take;
	logic              fwd_hit;

	pix_res_t          oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  oq_wp_q;
	logic [OQ_AW-1:0]  oq_rp_q;
	logic [OQ_CW-1:0]  oq_cnt_q;
	logic              oq_full;
	logic              oq_rd;
	pix_res_t          res_new;

	// Stage handshake
	assign oq_full = (oq_cnt_q == OQ_CW'(OQ_DEPTH));
	assign adv     = valid_s1 && !oq_full;
	assign take    = !iq_empty && (!valid_s1 || adv);
	assign iq_pop  = take;
	assign fwd_hit = adv && (iq_item.pos == item_s1.pos);

	// History: forward a same-edge write, zero when flagged invalid
	always_comb begin
		if (item_s1.invalid) begin
			prev = '0;
		end else if (fwd_q) begin
			prev = fwd_data_q;
		end else begin
			prev = rd_s1;
		end
	end

	assign wr_data = {filter_chan(item_s1.red,   prev[3*CH_W-1:2*CH_W], level),
	                  filter_chan(item_s1.green, prev[2*CH_W-1:CH_W],   level),
	                  filter_chan(item_s1.blue,  prev[CH_W-1:0],        level)};

	always_comb begin
		res_new.red   = wr_data[3*CH_W-1:2*CH_W];
		res_new.green = wr_data[2*CH_W-1:CH_W];
		res_new.blue  = wr_data[CH_W-1:0];
		res_new.alpha = item_s1.alpha;
		res_new.last  = item_s1.last;
	end

	// Frame store: write back filtered pixel, registered read for next item
	always_ff @(posedge clk) begin
		if (adv) begin
			hist_mem[item_s1.pos] <= wr_data;
		end
		if (take) begin
			rd_s1 <= hist_mem[iq_item.pos];
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1    <= iq_item;
			fwd_data_q <= wr_data;
		end
	end

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !adv);
			if (take) begin
				fwd_q <= fwd_hit;
			end
		end
	end

	// Result queue
	assign empty = (oq_cnt_q == '0);
	assign oq_rd = pop && !empty;
	assign res   = oq_q[oq_rp_q];

	always_ff @(posedge clk) begin
		if (adv) begin
			oq_q[oq_wp_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= '0;
			oq_rp_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (adv) begin
				oq_wp_q <= (oq_wp_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wp_q + OQ_AW'(1);
			end
			if (oq_rd) begin
				oq_rp_q <= (oq_rp_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rp_q + OQ_AW'(1);
			end
			if (adv && !oq_rd) begin
				oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
			end else if (oq_rd && !adv) begin
				oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
			end
		end
	end

	`CHK_NEXT(a_fwd_set, take && fwd_hit, fwd_q, "missed same-address forward")
	`CHK_IMPL(a_oq_bound, 1'b1, oq_cnt_q <= OQ_CW'(OQ_DEPTH), "result queue count over depth")

endmodule

@@ design/temporal_pixel_noise_reduction.sv @@
// Path: input queue, stage register, result queue. Throughput: one pixel per
// clock while the result queue is not full, set by the single read and write
// port of the frame store; same-position back-to-back pixels use a write forward.
// Reset: asynchronous, active low; clears queues, position (0), level (10) and
// frame size (4194304). Frame store contents are not cleared.
// ----------------------------------------------------------------------------
// temporal_pixel_noise_reduction
// Temporal RGB noise filter against a frame store of filtered history.
// ----------------------------------------------------------------------------
module temporal_pixel_noise_reduction
	import tpnr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input item queue side
	input  logic                  push,
	output logic                  full,
	input  logic [CH_W-1:0]       red_in,
	input  logic [CH_W-1:0]       green_in,
	input  logic [CH_W-1:0]       blue_in,
	input  logic [CH_W-1:0]       alpha_in,
	input  logic                  history_invalid,
	// result item queue side
	output logic                  empty,
	input  logic                  pop,
	output logic [CH_W-1:0]       red_out,
	output logic [CH_W-1:0]       green_out,
	output logic [CH_W-1:0]       blue_out,
	output logic [CH_W-1:0]       alpha_out,
	output logic                  frame_end,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LEVEL_W-1:0] level_q;
	logic [CNT_W-1:0]   frame_pixels_q;
	logic               iq_push;
	pix_item_t          iq_wr_item;
	logic               iq_full;
	logic               iq_pop;
	pix_item_t          iq_rd_item;
	logic               iq_empty;
	pix_res_t           res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q        <= LEVEL_RST;
			frame_pixels_q <= FRAME_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEVEL:        level_q        <= cfg_data[LEVEL_W-1:0];
				REG_FRAME_PIXELS: frame_pixels_q <= cfg_data[CNT_W-1:0];
				default:          ;
			endcase
		end
	end

	assign full = iq_full;

	tpnr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.alpha_in        (alpha_in),
		.history_invalid (history_invalid),
		.frame_pixels    (frame_pixels_q),
		.iq_full         (iq_full),
		.iq_push         (iq_push),
		.iq_item         (iq_wr_item)
	);

	tpnr_fifo u_iq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (iq_push),
		.wr_item (iq_wr_item),
		.full    (iq_full),
		.rd      (iq_pop),
		.rd_item (iq_rd_item),
		.empty   (iq_empty)
	);

	tpnr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.level    (level_q),
		.iq_empty (iq_empty),
		.iq_item  (iq_rd_item),
		.iq_pop   (iq_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	// Result fields
	assign red_out   = res.red;
	assign green_out = res.green;
	assign blue_out  = res.blue;
	assign alpha_out = res.alpha;
	assign frame_end = res.last;

endmodule
